// File: hw/rtl/rpsb_pkg.sv
package rpsb_pkg;

	localparam int DEPTH_DEF   = 32;
	localparam int HANDLE_BITS = 16;
	localparam int ADDR_BITS   = 48;
	localparam int TIME_BITS   = 48;
	localparam int DELAY_BITS  = 15;
	localparam int OCC_BITS    = 6;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_ROUTE = 2'd1;
	localparam logic [1:0] OP_SWEEP = 2'd2;

	localparam logic [2:0] K_SEND    = 3'd0;
	localparam logic [2:0] K_EXPIRED = 3'd1;
	localparam logic [2:0] K_ADDED   = 3'd2;
	localparam logic [2:0] K_FULL    = 3'd3;
	localparam logic [2:0] K_NONE    = 3'd4;

	localparam logic [DELAY_BITS-1:0] DELAY_STEP = DELAY_BITS'(1000);
	localparam logic [DELAY_BITS-1:0] DELAY_MAX  = '1;

	typedef struct packed {
		logic [1:0]             operation;
		logic [ADDR_BITS-1:0]   dest_addr;
		logic [HANDLE_BITS-1:0] msg_handle;
		logic [TIME_BITS-1:0]   now_us;
	} in_item_t;

	typedef struct packed {
		logic [2:0]             kind;
		logic [ADDR_BITS-1:0]   out_dest;
		logic [HANDLE_BITS-1:0] out_msg;
		logic [DELAY_BITS-1:0]  send_delay_us;
		logic                   last;
		logic [OCC_BITS-1:0]    occupancy;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0]   dest;
		logic [HANDLE_BITS-1:0] msg;
		logic [TIME_BITS-1:0]   deadline;
	} entry_t;

	// shift and write controls shared by every cell of the chain
	typedef struct packed {
		logic shift;
		logic wr;
	} cell_ctl_t;

endpackage

// File: hw/rtl/rpsb_cell.sv
module rpsb_cell
	import rpsb_pkg::*;
#(
	parameter int IW  = 5,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [IW-1:0] wpos,
	input  entry_t        wr_data,
	input  entry_t        right,
	output entry_t        data
);
	entry_t data_q;
	logic   sel;

	assign sel  = ctl.wr && (wpos == IW'(IDX));
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (sel) begin
			data_q <= wr_data;
		end else if (ctl.shift) begin
			data_q <= right;
		end
	end
endmodule

// File: hw/rtl/route_pending_send_buffer.sv
// Route-pending send buffer, built as a left-shifting chain of entry cells.
// Add and unknown codes: the result register is loaded on acceptance.
// Route-found and sweep: the chain is walked entry by entry, then flushed;
// no new item is taken until the walk is done.
// Reset (arst_n low, asynchronous) empties the buffer and sets hold time to 1 s.
module route_pending_send_buffer
	import rpsb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [31:0] cfg_data
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;

	logic [1:0]  state_q;
	logic [31:0] hold_q;
	logic [CW-1:0] count_q, rem_q, keep_q, n0_q, pend_rank_q;
	logic [1:0]  op_q;
	logic [ADDR_BITS-1:0] key_q;
	logic [TIME_BITS-1:0] now_q;
	logic        pend_v_q;
	logic [ADDR_BITS-1:0]   pend_dest_q;
	logic [HANDLE_BITS-1:0] pend_msg_q;
	logic [DELAY_BITS-1:0] pend_delay_q, hit_delay_q;
	logic        out_valid_q;
	out_item_t   out_q;

	entry_t    cell_d [DEPTH];
	entry_t    wr_data;
	cell_ctl_t ctl;
	logic [IW-1:0] wpos;
	logic [CW-1:0] tail;

	logic can_load, accept, step, hit, load;
	out_item_t load_val;
	logic [TIME_BITS:0] dl_sum;
	logic [DELAY_BITS:0] dsum;
	logic [DELAY_BITS-1:0] dnext;

	assign can_load = !out_valid_q || !out_stall;
	assign in_stall = !(state_q == ST_IDLE && can_load);
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// deadline: now + hold, clamped at the top of the time range
	assign dl_sum = {1'b0, in_data.now_us} + (TIME_BITS + 1)'(hold_q);

	// walk one entry per cycle; results wait for room in the output register
	assign step = (state_q == ST_SCAN) && (rem_q != '0) && can_load;
	assign hit  = (op_q == OP_ROUTE) ? (cell_d[0].dest == key_q)
	                                 : (now_q >= cell_d[0].deadline);

	// unprocessed entries sit at 0..rem-1, survivors follow them
	assign tail = rem_q + keep_q - CW'(1);

	// rank delay: grows by 1000 per send, clamped at the field top
	assign dsum  = {1'b0, hit_delay_q} + {1'b0, DELAY_STEP};
	assign dnext = dsum[DELAY_BITS] ? DELAY_MAX : dsum[DELAY_BITS-1:0];

	always_comb begin
		ctl.shift = step;
		ctl.wr    = 1'b0;
		wpos      = count_q[IW-1:0];
		wr_data.dest     = in_data.dest_addr;
		wr_data.msg      = in_data.msg_handle;
		wr_data.deadline = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
		if (state_q == ST_IDLE) begin
			ctl.wr = accept && in_data.operation == OP_ADD && count_q < CW'(DEPTH);
		end else begin
			ctl.wr  = step && !hit;
			wpos    = tail[IW-1:0];
			wr_data = cell_d[0];
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t right;
		if (i < DEPTH - 1) begin : g_mid
			assign right = cell_d[i+1];
		end else begin : g_end
			assign right = '0;
		end
		rpsb_cell #(.IW(IW), .IDX(i)) u_cell (
			.clk(clk), .ctl(ctl), .wpos(wpos), .wr_data(wr_data),
			.right(right), .data(cell_d[i])
		);
	end

	// result selection
	always_comb begin
		load     = 1'b0;
		load_val = '0;
		load_val.kind = K_NONE;
		load_val.last = 1'b1;
		load_val.occupancy = OCC_BITS'(count_q);
		if (state_q == ST_IDLE) begin
			if (accept) begin
				if (in_data.operation == OP_ADD) begin
					load = 1'b1;
					load_val.out_dest = in_data.dest_addr;
					load_val.out_msg  = in_data.msg_handle;
					if (count_q < CW'(DEPTH)) begin
						load_val.kind = K_ADDED;
						load_val.occupancy = OCC_BITS'(count_q + CW'(1));
					end else begin
						load_val.kind = K_FULL;
					end
				end else if (in_data.operation != OP_ROUTE &&
				             in_data.operation != OP_SWEEP) begin
					load = 1'b1;
				end
			end
		end else if (can_load && (rem_q == '0 || (hit && pend_v_q))) begin
			// a pending hit goes out once the next hit or the end is seen
			load = 1'b1;
			if (pend_v_q) begin
				load_val.kind = (op_q == OP_ROUTE) ? K_SEND : K_EXPIRED;
				load_val.out_dest = pend_dest_q;
				load_val.out_msg  = pend_msg_q;
				load_val.send_delay_us = (op_q == OP_ROUTE) ? pend_delay_q : '0;
				load_val.last = (rem_q == '0);
				load_val.occupancy = OCC_BITS'(n0_q - pend_rank_q);
			end else begin
				load_val.occupancy = OCC_BITS'(keep_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hold_q      <= 32'd1000000;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
			rem_q       <= '0;
			keep_q      <= '0;
		end else begin
			if (cfg_we) begin
				hold_q <= cfg_data;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				if (accept) begin
					if (ctl.wr) begin
						count_q <= count_q + CW'(1);
					end
					if (in_data.operation == OP_ROUTE || in_data.operation == OP_SWEEP) begin
						state_q  <= ST_SCAN;
						rem_q    <= count_q;
						keep_q   <= '0;
						pend_v_q <= 1'b0;
					end
				end
			end else if (step) begin
				rem_q <= rem_q - CW'(1);
				if (hit) begin
					pend_v_q <= 1'b1;
				end else begin
					keep_q <= keep_q + CW'(1);
				end
			end else if (rem_q == '0 && can_load) begin
				count_q <= keep_q;
				state_q <= ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_val;
		end
		if (accept) begin
			op_q  <= in_data.operation;
			key_q <= in_data.dest_addr;
			now_q <= in_data.now_us;
			n0_q  <= count_q;
			hit_delay_q <= '0;
			pend_rank_q <= '0;
		end else if (step && hit) begin
			pend_dest_q  <= cell_d[0].dest;
			pend_msg_q   <= cell_d[0].msg;
			pend_rank_q  <= pend_rank_q + CW'(1);
			pend_delay_q <= dnext;
			hit_delay_q  <= dnext;
		end
	end
endmodule

// File: hw/rtl/rpsb_checker.sv
module rpsb_checker
	import rpsb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.occupancy <= OCC_BITS'(DEPTH))
		else $error("occupancy beyond depth");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == K_ADDED || out_data.kind == K_FULL ||
		              out_data.kind == K_NONE) |-> out_data.last)
		else $error("single result without last");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == K_NONE |->
		out_data.out_dest == '0 && out_data.out_msg == '0 &&
		out_data.send_delay_us == '0)
		else $error("none result carries data");
endmodule

bind route_pending_send_buffer rpsb_checker #(.DEPTH(DEPTH)) u_rpsb_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data)
);
